// ===== rtl/wrl_pkg.sv =====
// Shared types, constants and register codes for the windowed rate limiter.
// No dependencies; every other rtl file imports this package.
`default_nettype none

package wrl_pkg;

    // Field widths
    localparam int MAX_BLOCK_BYTES = 4096;
    localparam int TIME_BITS       = 48;
    localparam int BYTES_W         = 13;
    localparam int CNT_W           = 31;
    localparam int SUM_W           = CNT_W + 1;
    localparam int TPB_W           = 32;
    localparam int MIN_W           = 32;
    localparam int FRAC_BITS       = 16;
    localparam int PROD_W          = CNT_W + TPB_W;
    localparam int BUDGET_W        = PROD_W - FRAC_BITS;
    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = 48;
    localparam int IN_TDATA_W      = 64;
    localparam int OUT_TDATA_W     = 48;

    // Register reset values
    localparam logic [TPB_W-1:0]     TPB_RESET    = 32'd65536;
    localparam logic [TIME_BITS-1:0] WINDOW_RESET = 48'd60000000;
    localparam logic [MIN_W-1:0]     MIN_RESET    = 32'd1;

    // Register indexes on the configuration channel
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TICKS_PER_BYTE = 2'd0,
        CFG_WINDOW_TICKS   = 2'd1,
        CFG_MIN_DELAY      = 2'd2
    } t_cfg_idx;

    // Live configuration
    typedef struct packed {
        logic [TPB_W-1:0]     ticks_per_byte;
        logic [TIME_BITS-1:0] window_ticks;
        logic [MIN_W-1:0]     min_delay_ticks;
    } t_cfg;

    // Word handed from window accounting to the budget pipeline
    typedef struct packed {
        logic [CNT_W-1:0]     cnt;      // bytes in window, this block included
        logic [TIME_BITS-1:0] elapsed;  // ticks since window start, 0 on restart
        logic                 restart;
    } t_win_item;

endpackage

`default_nettype wire

// ===== rtl/wrl_cfg_regs.sv =====
// Configuration register file: ticks per byte, window length, minimum delay.
// Depends on wrl_pkg.
`default_nettype none

module wrl_cfg_regs
    import wrl_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  i_wr_index,
    input  wire logic [CFG_DATA_W-1:0] i_wr_data,
    output t_cfg                       o_cfg
);

    t_cfg r_cfg;

    // Register writes; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ticks_per_byte  <= TPB_RESET;
            r_cfg.window_ticks    <= WINDOW_RESET;
            r_cfg.min_delay_ticks <= MIN_RESET;
        end else if (i_wr_en) begin
            case (t_cfg_idx'(i_wr_index))
                CFG_TICKS_PER_BYTE: r_cfg.ticks_per_byte  <= i_wr_data[TPB_W-1:0];
                CFG_WINDOW_TICKS:   r_cfg.window_ticks    <= i_wr_data[TIME_BITS-1:0];
                CFG_MIN_DELAY:      r_cfg.min_delay_ticks <= i_wr_data[MIN_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ===== rtl/wrl_window.sv =====
// Input register and window accounting: restart decision, byte count, elapsed.
// Depends on wrl_pkg.
`default_nettype none

module wrl_window
    import wrl_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire t_cfg                 i_cfg,
    input  wire logic                 i_valid,
    output logic                      o_ready,
    input  wire logic [BYTES_W-1:0]   i_bytes,
    input  wire logic [TIME_BITS-1:0] i_now,
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output t_win_item                 o_item
);

    // Input stage
    logic                 r_a_valid;
    logic [BYTES_W-1:0]   r_a_bytes;
    logic [TIME_BITS-1:0] r_a_now;

    // Output stage
    logic      r_b_valid;
    t_win_item r_b_item;

    // Window state
    logic [TIME_BITS-1:0] r_window_start;
    logic [CNT_W-1:0]     r_window_bytes;
    logic [TIME_BITS-1:0] r_last_elapsed;
    logic                 r_pending;

    logic                 load_a;
    logic                 load_b;
    logic                 move_ab;
    logic [BYTES_W-1:0]   bytes_c;
    logic [SUM_W-1:0]     sum;
    logic [TIME_BITS-1:0] elapsed;
    logic                 restart;
    t_win_item            n_b_item;

    // Stage advance: each stage loads when empty or when its word moves on
    assign load_b  = !r_b_valid || i_ready;
    assign load_a  = !r_a_valid || load_b;
    assign move_ab = r_a_valid && load_b;
    assign o_ready = load_a;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (load_a) begin
            r_a_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_a && i_valid) begin
            r_a_bytes <= i_bytes;
            r_a_now   <= i_now;
        end
    end

    // Accounting for the word in the input stage
    always_comb begin
        bytes_c = (r_a_bytes > BYTES_W'(MAX_BLOCK_BYTES)) ?
                  BYTES_W'(MAX_BLOCK_BYTES) : r_a_bytes;
        sum     = SUM_W'(r_window_bytes) + SUM_W'(bytes_c);
        elapsed = r_a_now - r_window_start;
        restart = r_pending || (r_last_elapsed >= i_cfg.window_ticks) || sum[SUM_W-1];
        if (restart) begin
            n_b_item.cnt     = CNT_W'(bytes_c);
            n_b_item.elapsed = '0;
        end else begin
            n_b_item.cnt     = sum[CNT_W-1:0];
            n_b_item.elapsed = elapsed;
        end
        n_b_item.restart = restart;
    end

    // Window state moves once per word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_start <= '0;
            r_window_bytes <= '0;
            r_last_elapsed <= '0;
            r_pending      <= 1'b1;
        end else if (move_ab) begin
            r_window_bytes <= n_b_item.cnt;
            r_last_elapsed <= n_b_item.elapsed;
            r_pending      <= 1'b0;
            if (restart) begin
                r_window_start <= r_a_now;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (load_b) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (move_ab) begin
            r_b_item <= n_b_item;
        end
    end

    assign o_valid = r_b_valid;
    assign o_item  = r_b_item;

    // A word waiting downstream always matches the window state it left behind
    a_cnt_tracks_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_b_valid |-> r_b_item.cnt == r_window_bytes)
        else $error("window count out of step with pending word");

    a_elapsed_tracks_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_b_valid |-> r_b_item.elapsed == r_last_elapsed)
        else $error("elapsed out of step with pending word");

    a_first_word_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        move_ab |=> !r_pending)
        else $error("restart still pending after a word");

    a_ready_when_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_b_valid |-> o_ready)
        else $error("input stalled with an empty output stage");

endmodule

`default_nettype wire

// ===== rtl/wrl_budget.sv =====
// Budget multiply, delay subtract and minimum check, then the result register.
// Depends on wrl_pkg.
`default_nettype none

module wrl_budget
    import wrl_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_cfg                  i_cfg,
    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  wire t_win_item             i_item,
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output logic [TIME_BITS-1:0]       o_hold,
    output logic                       o_restart
);

    // Multiply stage
    logic                 r_c_valid;
    logic [BUDGET_W-1:0]  r_c_budget;
    logic [TIME_BITS-1:0] r_c_elapsed;
    logic                 r_c_restart;

    // Result stage
    logic                 r_d_valid;
    logic [TIME_BITS-1:0] r_d_hold;
    logic                 r_d_restart;

    logic                 load_c;
    logic                 load_d;
    logic [PROD_W-1:0]    prod;
    logic [TIME_BITS-1:0] budget_x;
    logic [TIME_BITS-1:0] n_d_hold;

    assign load_d  = !r_d_valid || i_ready;
    assign load_c  = !r_c_valid || load_d;
    assign o_ready = load_c;

    // Q16.16 budget, fraction dropped
    assign prod = PROD_W'(i_item.cnt) * PROD_W'(i_cfg.ticks_per_byte);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else if (load_c) begin
            r_c_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_c && i_valid) begin
            r_c_budget  <= prod[PROD_W-1:FRAC_BITS];
            r_c_elapsed <= i_item.elapsed;
            r_c_restart <= i_item.restart;
        end
    end

    // Delay = budget - elapsed, zero when overspent or below the minimum.
    // Budget is at most 47 bits, so the 48-bit result never saturates.
    always_comb begin
        budget_x = TIME_BITS'(r_c_budget);
        if (r_c_elapsed > budget_x) begin
            n_d_hold = '0;
        end else begin
            n_d_hold = budget_x - r_c_elapsed;
        end
        if (n_d_hold < TIME_BITS'(i_cfg.min_delay_ticks)) begin
            n_d_hold = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_valid <= 1'b0;
        end else if (load_d) begin
            r_d_valid <= r_c_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_d && r_c_valid) begin
            r_d_hold    <= n_d_hold;
            r_d_restart <= r_c_restart;
        end
    end

    assign o_valid   = r_d_valid;
    assign o_hold    = r_d_hold;
    assign o_restart = r_d_restart;

    a_hold_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_d_valid |-> !r_d_hold[TIME_BITS-1])
        else $error("hold exceeds the budget range");

    a_mid_stage_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_c_valid && !load_d |=> r_c_valid)
        else $error("multiply stage word lost under stall");

    a_ready_when_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_c_valid |-> o_ready)
        else $error("budget input stalled with an empty multiply stage");

endmodule

`default_nettype wire

// ===== rtl/windowed_rate_limiter_top.sv =====
// Top level of the windowed rate limiter: config registers, window accounting
// and budget pipeline. Depends on wrl_pkg, wrl_cfg_regs, wrl_window, wrl_budget.
//
//   channel  direction  handshake                  payload
//   s_axis   in         i_s_axis_tvalid/o_..tready tdata: block_bytes, now_ticks
//   m_axis   out        o_m_axis_tvalid/i_..tready tdata: hold_ticks; tuser: restart
//   cfg      in         i_cfg_valid/o_cfg_ready    i_cfg_index, i_cfg_data
//
// One word per cycle sustained unless the output stalls; four register stages
// (input reg, window reg, multiply reg, result reg), which an accepted input
// word passes through in that order before result valid rises.
// The rate is set by the window-state update loop in wrl_window.
// Synchronous active-low reset empties the pipeline and restores register
// defaults; the first word after reset opens a window.
// A stalled output backs up stage by stage; empty stages keep accepting.
`default_nettype none

module windowed_rate_limiter_top
    import wrl_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    // [12:0] block_bytes, [60:13] now_ticks, [63:61] zero
    input  wire logic [IN_TDATA_W-1:0]  i_s_axis_tdata,
    input  wire logic                   i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    // [47:0] hold_ticks
    output logic [OUT_TDATA_W-1:0]      o_m_axis_tdata,
    // [0] window_restarted
    output logic                        o_m_axis_tuser,
    output logic                        o_m_axis_tvalid,
    input  wire logic                   i_m_axis_tready,
    input  wire logic                   i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_data
);

    t_cfg      cfg;
    logic      win_valid;
    logic      win_ready;
    t_win_item win_item;

    // Register writes are always taken
    assign o_cfg_ready = 1'b1;

    wrl_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg_valid),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .o_cfg      (cfg)
    );

    wrl_window u_window (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_bytes (i_s_axis_tdata[BYTES_W-1:0]),
        .i_now   (i_s_axis_tdata[BYTES_W+TIME_BITS-1:BYTES_W]),
        .o_valid (win_valid),
        .i_ready (win_ready),
        .o_item  (win_item)
    );

    wrl_budget u_budget (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_valid   (win_valid),
        .o_ready   (win_ready),
        .i_item    (win_item),
        .o_valid   (o_m_axis_tvalid),
        .i_ready   (i_m_axis_tready),
        .o_hold    (o_m_axis_tdata),
        .o_restart (o_m_axis_tuser)
    );

endmodule

`default_nettype wire
